// ----- rtl/lgs_pkg.sv -----
// Shared types, constants and the neighbor rule for the life generation step block.
package lgs_pkg;

    localparam int ROW_W = 64;
    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] WIDTH_RESET = 7'd64;

    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] SURVIVE_LOW = 4'd2;
    localparam logic [CNT_W-1:0] BIRTH_COUNT = 4'd3;

    localparam int RES_DEPTH = 4;
    localparam int PTR_W = $clog2(RES_DEPTH);

    typedef struct packed {
        logic above;
        logic mid;
        logic row;
    } lgs_col_t;

    typedef struct packed {
        logic load;
        logic clear;
    } lgs_ctl_t;

    typedef struct packed {
        logic [ROW_W-1:0] cells;
        logic             last;
    } lgs_res_t;

    function automatic logic [CNT_W-1:0] nbr_count(input logic [7:0] v);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + CNT_W'(v[i]);
        end
        return n;
    endfunction

    function automatic logic life_rule(input logic alive, input logic [CNT_W-1:0] n);
        logic next;
        if (alive)
        begin
            next = (n == SURVIVE_LOW) || (n == BIRTH_COUNT);
        end
        else
        begin
            next = (n == BIRTH_COUNT);
        end
        return next;
    endfunction

endpackage

// ----- rtl/lgs_in_if.sv -----
// Input row channel: valid, ready and one board row with its final-row flag.
interface lgs_in_if;
    import lgs_pkg::*;

    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row_cells;
    logic             last_row;

    modport source (output valid, output row_cells, output last_row, input ready);
    modport sink (input valid, input row_cells, input last_row, output ready);
endinterface

// ----- rtl/lgs_out_if.sv -----
// Result row channel: valid, ready and one next-generation row with its final flag.
interface lgs_out_if;
    import lgs_pkg::*;

    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] next_cells;
    logic             last_out;

    modport source (output valid, output next_cells, output last_out, input ready);
    modport sink (input valid, input next_cells, input last_out, output ready);
endinterface

// ----- rtl/lgs_cell.sv -----
// One board column: holds the two buffered rows and evaluates both result rules.
module lgs_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  lgs_pkg::lgs_ctl_t  ctl,
    input  logic               col_en,
    input  logic               in_bit,
    input  lgs_pkg::lgs_col_t  left_col,
    input  lgs_pkg::lgs_col_t  right_col,
    output lgs_pkg::lgs_col_t  col_out,
    output logic               res_a,
    output logic               res_b
);
    import lgs_pkg::*;

    logic             above_reg;
    logic             mid_reg;
    logic             row_bit;
    logic [CNT_W-1:0] n_a;
    logic [CNT_W-1:0] n_b;

    assign row_bit = in_bit & col_en;

    assign col_out.above = above_reg;
    assign col_out.mid   = mid_reg;
    assign col_out.row   = row_bit;

    assign n_a = nbr_count({left_col.above, above_reg, right_col.above,
                            left_col.mid, right_col.mid,
                            left_col.row, row_bit, right_col.row});
    assign n_b = nbr_count({left_col.mid, mid_reg, right_col.mid,
                            left_col.row, right_col.row,
                            3'b000});

    assign res_a = col_en & life_rule(mid_reg, n_a);
    assign res_b = col_en & life_rule(row_bit, n_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            above_reg <= 1'b0;
            mid_reg   <= 1'b0;
        end
        else if (ctl.load)
        begin
            if (ctl.clear)
            begin
                above_reg <= 1'b0;
                mid_reg   <= 1'b0;
            end
            else
            begin
                above_reg <= mid_reg;
                mid_reg   <= row_bit;
            end
        end
    end

endmodule

// ----- rtl/lgs_res_fifo.sv -----
// Result queue: takes up to two result beats a cycle and gives out one.
module lgs_res_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_cnt,
    input  lgs_pkg::lgs_res_t push0,
    input  lgs_pkg::lgs_res_t push1,
    input  logic              pop,
    output lgs_pkg::lgs_res_t head,
    output logic              not_empty,
    output logic              room
);
    import lgs_pkg::*;

    localparam int QC_W = PTR_W + 1;

    lgs_res_t          mem_reg [RES_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [QC_W-1:0]   count_reg;
    logic [QC_W-1:0]   count_next;
    logic [PTR_W-1:0]  wr_ptr_1;

    assign wr_ptr_1  = wr_ptr_reg + PTR_W'(1);
    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign room      = (count_reg <= QC_W'(RES_DEPTH - 2));
    assign count_next = count_reg + QC_W'(push_cnt) - QC_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            mem_reg[wr_ptr_1] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_cnt);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt != 2'd0) |-> room)
        else $error("result beat pushed without room");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QC_W'(RES_DEPTH))
        else $error("result queue overflow");

endmodule

// ----- rtl/life_generation_step_core.sv -----
// Top level of the life generation step block: column cells, control and result queue.
// Streams a board one row per beat and returns next-generation rows. A row is taken
// every cycle while the result queue holds at most two beats. Each row after the first
// yields one result. A final row after the first yields two, and a board of one row
// yields one. With the output side taking a beat every cycle the queue never holds more
// than two beats, so the input never pauses; it waits only while the output stalls. A
// result is pushed into the result queue when its row is taken. All columns are
// evaluated at once by a row of column cells, each exchanging its buffered bits with
// its two neighbors; there is no clearing pass.
module life_generation_step_core #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [lgs_pkg::CFG_W-1:0] cfg_wdata,
    lgs_in_if.sink                    row_in,
    lgs_out_if.source                 row_out
);
    import lgs_pkg::*;

    logic [CFG_W-1:0] board_width_reg;
    logic             seen_reg;
    logic             seen_next;
    logic             accept;
    logic             room;
    logic             not_empty;
    lgs_ctl_t         ctl;
    lgs_col_t         col_vec [ROW_W+2];
    logic [ROW_W-1:0] res_a_vec;
    logic [ROW_W-1:0] res_b_vec;
    logic [1:0]       push_cnt;
    lgs_res_t         push0;
    lgs_res_t         push1;
    lgs_res_t         head;

    assign accept       = row_in.valid && row_in.ready;
    assign row_in.ready = room;

    assign ctl.load  = accept;
    assign ctl.clear = row_in.last_row;

    assign col_vec[0]       = '0;
    assign col_vec[ROW_W+1] = '0;

    for (genvar k = 0; k < ROW_W; k++)
    begin : g_col
        if (k < MAX_WIDTH)
        begin : g_cell
            lgs_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .col_en    (board_width_reg > CFG_W'(k)),
                .in_bit    (row_in.row_cells[k]),
                .left_col  (col_vec[k]),
                .right_col (col_vec[k+2]),
                .col_out   (col_vec[k+1]),
                .res_a     (res_a_vec[k]),
                .res_b     (res_b_vec[k])
            );
        end
        else
        begin : g_pad
            assign col_vec[k+1] = '0;
            assign res_a_vec[k] = 1'b0;
            assign res_b_vec[k] = 1'b0;
        end
    end

    assign push_cnt    = accept ? {seen_reg & row_in.last_row, seen_reg ^ row_in.last_row}
                                : 2'd0;
    assign push0.cells = seen_reg ? res_a_vec : res_b_vec;
    assign push0.last  = !seen_reg;
    assign push1.cells = res_b_vec;
    assign push1.last  = 1'b1;

    assign seen_next = accept ? !row_in.last_row : seen_reg;

    lgs_res_fifo u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push0     (push0),
        .push1     (push1),
        .pop       (row_out.valid && row_out.ready),
        .head      (head),
        .not_empty (not_empty),
        .room      (room)
    );

    assign row_out.valid      = not_empty;
    assign row_out.next_cells = head.cells;
    assign row_out.last_out   = head.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_width_reg <= WIDTH_RESET;
            seen_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                board_width_reg <= cfg_wdata;
            end
            seen_reg <= seen_next;
        end
    end

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && row_in.last_row) |=> !seen_reg)
        else $error("board state not cleared after final row");

    a_row_buffers: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !row_in.last_row) |=> seen_reg)
        else $error("row not buffered");

    a_upper_dead: assert property (@(posedge clk) disable iff (!rst_n)
        row_out.valid |-> ((row_out.next_cells >> MAX_WIDTH) == '0))
        else $error("live cell beyond board columns");

endmodule
